@@ src/rc_serial_frame_receiver_defines.svh @@
// Assertion macros used by the receiver's channel sequencer.
`ifndef RC_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define RC_SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RCSFR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsfr assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RCSFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsfr assertion failed");

`endif

@@ src/rcsfr_pkg.sv @@
// Package with constants and types of the serial RC frame receiver.
`timescale 1ns / 1ps
package rcsfr_pkg;

    localparam int DEF_MAX_MSG_LEN = 32;
    localparam int DEF_CHANNELS    = 14;
    localparam int OVERHEAD        = 3;
    localparam int CHAN_IDX_W      = 6;
    localparam int POS_W           = CHAN_IDX_W + 1;

    localparam logic [7:0]  CMD_SET_OUTPUT = 8'h40;
    localparam logic [15:0] SUM_SEED       = 16'hFFFF;
    localparam logic [7:0]  GAP_RESET      = 8'd3;

    typedef enum logic [2:0] {
        PH_LENGTH  = 3'd0,
        PH_DATA    = 3'd1,
        PH_SUM_LO  = 3'd2,
        PH_SUM_HI  = 3'd3,
        PH_DISCARD = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_LO   = 2'd1,
        EM_HI   = 2'd2,
        EM_OUT  = 2'd3
    } emit_state_t;

endpackage

@@ src/rcsfr_frame_mem.sv @@
// Frame byte store: one write port, one registered read port, reset-cleared valid bits.
`timescale 1ns / 1ps
module rcsfr_frame_mem #(
    parameter int DEPTH  = 29,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 8'd0;
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ src/rcsfr_parser.sv @@
// Byte parser: gap detection, length check, checksum and frame store writes.
`timescale 1ns / 1ps
module rcsfr_parser #(
    parameter int MAX_MSG_LEN = 32,
    parameter int ADDR_W      = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    input  logic [31:0]       now_ms,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              start
);
    import rcsfr_pkg::*;

    localparam int LEN_W = $clog2(MAX_MSG_LEN + 1);

    phase_t         phase_reg, phase_next, phase_eff;
    logic [7:0]     gap_reg;
    logic [31:0]    last_reg, last_next;
    logic [LEN_W-1:0] off_reg, off_next, len_reg, len_next, off_inc;
    logic [15:0]    sum_reg, sum_next;
    logic [7:0]     lo_reg, lo_next;
    logic [7:0]     cmd_reg, cmd_next;
    logic [31:0]    elapsed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            gap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LENGTH;
            last_reg  <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            lo_reg    <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            lo_reg    <= lo_next;
            cmd_reg   <= cmd_next;
        end
    end

    assign elapsed = now_ms - last_reg;
    assign off_inc = off_reg + LEN_W'(1);
    assign phase_eff = (elapsed >= {24'd0, gap_reg}) ? PH_LENGTH : phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        last_next  = last_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        lo_next    = lo_reg;
        cmd_next   = cmd_reg;
        wr_en      = 1'b0;
        start      = 1'b0;
        if (accept)
        begin
            last_next  = now_ms;
            phase_next = phase_eff;
            unique case (phase_eff)
                PH_LENGTH:
                begin
                    if (rx_byte <= 8'(MAX_MSG_LEN) && rx_byte > 8'(OVERHEAD))
                    begin
                        off_next   = '0;
                        len_next   = LEN_W'(rx_byte - 8'(OVERHEAD));
                        sum_next   = SUM_SEED - {8'd0, rx_byte};
                        phase_next = PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_DISCARD;
                    end
                end
                PH_DATA:
                begin
                    wr_en    = 1'b1;
                    off_next = off_inc;
                    sum_next = sum_reg - {8'd0, rx_byte};
                    if (off_reg == '0)
                    begin
                        cmd_next = rx_byte;
                    end
                    if (off_inc == len_reg)
                    begin
                        phase_next = PH_SUM_LO;
                    end
                end
                PH_SUM_LO:
                begin
                    lo_next    = rx_byte;
                    phase_next = PH_SUM_HI;
                end
                PH_SUM_HI:
                begin
                    start      = (sum_reg == {rx_byte, lo_reg}) && (cmd_reg == CMD_SET_OUTPUT);
                    phase_next = PH_DISCARD;
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end
    end

    assign wr_addr = off_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;
endmodule

@@ src/rcsfr_emit.sv @@
// Channel sequencer: reads byte pairs from the frame store and drives the result register.
`timescale 1ns / 1ps
`include "rc_serial_frame_receiver_defines.svh"
module rcsfr_emit #(
    parameter int CHANNELS    = 14,
    parameter int FRAME_DEPTH = 29,
    parameter int ADDR_W      = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    output logic                             rd_en,
    output logic [ADDR_W-1:0]                rd_addr,
    input  logic [7:0]                       rd_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rcsfr_pkg::CHAN_IDX_W-1:0] out_index,
    output logic [15:0]                      out_value,
    output logic                             out_last
);
    import rcsfr_pkg::*;

    emit_state_t           state_reg, state_next;
    logic [CHAN_IDX_W-1:0] ch_reg, ch_next;
    logic                  rng_reg, rng_next;
    logic [7:0]            lo_reg, lo_next;
    logic                  ov_reg, ov_next;
    logic [CHAN_IDX_W-1:0] oidx_reg, oidx_next;
    logic [15:0]           oval_reg, oval_next;
    logic                  olast_reg, olast_next;
    logic [POS_W-1:0]      pos_lo, pos_hi, pos;
    logic [7:0]            rd_byte;
    logic                  is_last, load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            ch_reg    <= '0;
            rng_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            rng_reg   <= rng_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign pos_lo  = {ch_reg, 1'b1};
    assign pos_hi  = {ch_reg, 1'b0} + POS_W'(2);
    assign rd_byte = rng_reg ? rd_data : 8'd0;
    assign is_last = (ch_reg == CHAN_IDX_W'(CHANNELS - 1));

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        rng_next   = rng_reg;
        lo_next    = lo_reg;
        ov_next    = ov_reg & ~out_ready;
        oidx_next  = oidx_reg;
        oval_next  = oval_reg;
        olast_next = olast_reg;
        rd_en      = 1'b0;
        pos        = pos_lo;
        load       = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (start)
                begin
                    ch_next    = '0;
                    state_next = EM_LO;
                end
            end
            EM_LO:
            begin
                // Bytes past the store read as zero
                pos        = pos_lo;
                rng_next   = (pos_lo < POS_W'(FRAME_DEPTH));
                rd_en      = rng_next;
                state_next = EM_HI;
            end
            EM_HI:
            begin
                lo_next    = rd_byte;
                pos        = pos_hi;
                rng_next   = (pos_hi < POS_W'(FRAME_DEPTH));
                rd_en      = rng_next;
                state_next = EM_OUT;
            end
            EM_OUT:
            begin
                // Hold the read byte until the result register frees up
                if (!ov_reg || out_ready)
                begin
                    load       = 1'b1;
                    ov_next    = 1'b1;
                    oidx_next  = ch_reg;
                    oval_next  = {rd_byte, lo_reg};
                    olast_next = is_last;
                    if (is_last)
                    begin
                        state_next = EM_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + CHAN_IDX_W'(1);
                        state_next = EM_LO;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    assign rd_addr   = pos[ADDR_W-1:0];
    assign busy      = (state_reg != EM_IDLE);
    assign out_valid = ov_reg;
    assign out_index = oidx_reg;
    assign out_value = oval_reg;
    assign out_last  = olast_reg;

    `RCSFR_ASSERT_IMPLY(a_start_idle, clk, rst_n, start, state_reg == EM_IDLE)
    `RCSFR_ASSERT_IMPLY(a_last_index, clk, rst_n, ov_reg && olast_reg,
        oidx_reg == CHAN_IDX_W'(CHANNELS - 1))
    `RCSFR_ASSERT_NEXT(a_last_ends, clk, rst_n, load && is_last, state_reg == EM_IDLE)
endmodule

@@ src/rc_serial_frame_receiver.sv @@
// Top level of the serial RC frame receiver.
`timescale 1ns / 1ps
//
// Channel   Dir  Width  Contents
// s_axis    in   40     rx_byte, now_ms (one received byte per transfer)
// m_axis    out  24+1   channel_index, channel_value; tlast = last_channel
// cfg       in   8      gap_ms, written when cfg_we is high
//
// s_tready is high whenever no channel sweep runs, and bytes are taken as they come.
// A good frame starts a channel sweep in which each channel takes two frame
// store reads plus the result load; s_tready is low for the whole sweep.
// The single result register lets the sweep run on; m_tready stalls it only at the load step.
// rst_n clears parser state and the store's valid bits at once; no clearing pass.
module rc_serial_frame_receiver #(
    parameter int MAX_MSG_LEN = rcsfr_pkg::DEF_MAX_MSG_LEN,
    parameter int CHANNELS    = rcsfr_pkg::DEF_CHANNELS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // gap_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [7:0] rx_byte, [39:8] now_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [5:0] channel_index, [21:6] channel_value, [23:22] zero
    output logic        m_tlast        // last_channel
);
    import rcsfr_pkg::*;

    localparam int FRAME_DEPTH = MAX_MSG_LEN - OVERHEAD;
    localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    logic              accept;
    logic              busy;
    logic              start;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic [CHAN_IDX_W-1:0] out_index;
    logic [15:0]       out_value;

    // Stop taking bytes while a channel sweep owns the store's read side
    assign s_tready = ~busy;
    assign accept   = s_tvalid & s_tready;

    rcsfr_parser #(
        .MAX_MSG_LEN (MAX_MSG_LEN),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .rx_byte   (s_tdata[7:0]),
        .now_ms    (s_tdata[39:8]),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .start     (start)
    );

    rcsfr_frame_mem #(
        .DEPTH  (FRAME_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcsfr_emit #(
        .CHANNELS    (CHANNELS),
        .FRAME_DEPTH (FRAME_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_value, out_index};
endmodule
